@@ sv/har_pkg.sv @@
`default_nettype none
package har_pkg;

	localparam int unsigned DW      = 32;
	localparam int unsigned MAG_W   = 16;
	localparam int unsigned EST_W   = 16;
	localparam int unsigned QW      = 32;

	localparam logic [9:0] W_LARGE = 10'd1007;
	localparam logic [9:0] W_SMALL = 10'd967;
	localparam logic [8:0] W_MIN   = 9'd441;
	localparam logic [26:0] RND_EST = 27'd512;

	localparam logic [DW-1:0] TIER_LIM_0  = 32'd1 << 15;
	localparam logic [DW-1:0] TIER_LIM_4  = 32'd1 << 19;
	localparam logic [DW-1:0] TIER_LIM_8  = 32'd1 << 23;
	localparam logic [DW-1:0] TIER_LIM_12 = 32'd1 << 27;

	localparam int unsigned DIV_BITS   = 2;
	localparam int unsigned DIV_STAGES = QW / DIV_BITS;
	// s1..s4, divider stages, output stage
	localparam int unsigned HAR_DEPTH  = DIV_STAGES + 5;

	typedef struct packed {
		logic signed [DW-1:0] x_value;
		logic signed [DW-1:0] y_value;
	} har_in_t;

	typedef struct packed {
		logic [DW-1:0] length;
	} har_out_t;

	typedef enum logic [2:0] {
		TIER_0,
		TIER_4,
		TIER_8,
		TIER_12,
		TIER_16
	} har_tier_t;

	typedef struct packed {
		logic          byp;
		logic [DW-1:0] byp_val;
		har_tier_t     tier;
		logic [EST_W-1:0] est;
		logic [EST_W-1:0] rem;
		logic [QW-1:0] numq;
	} har_div_t;

	// restoring division, DIV_BITS quotient bits per call
	function automatic har_div_t har_div_step(input har_div_t a);
		har_div_t r;
		logic [EST_W:0] t;
		r = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.numq[QW-1]};
			if (t >= {1'b0, r.est}) begin
				r.rem  = EST_W'(t - {1'b0, r.est});
				r.numq = {r.numq[QW-2:0], 1'b1};
			end else begin
				r.rem  = t[EST_W-1:0];
				r.numq = {r.numq[QW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/har_stream_if.sv @@
`default_nettype none
interface har_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/har_div.sv @@
`default_nettype none
module har_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire har_pkg::har_div_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output har_pkg::har_div_t     out_data
);
	import har_pkg::*;

	logic                    v_s   [DIV_STAGES];
	har_div_t                d_s   [DIV_STAGES];
	logic                    src_v [DIV_STAGES];
	har_div_t                src_d [DIV_STAGES];
	logic [DIV_STAGES:0]     en;

	assign en[DIV_STAGES] = out_ready;
	assign in_ready       = en[0];
	assign out_valid      = v_s[DIV_STAGES-1];
	assign out_data       = d_s[DIV_STAGES-1];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign src_v[k] = in_valid;
			assign src_d[k] = in_data;
		end else begin : g_next
			assign src_v[k] = v_s[k-1];
			assign src_d[k] = d_s[k-1];
		end

		assign en[k] = !v_s[k] || en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_v[k]) begin
				d_s[k] <= har_div_step(src_d[k]);
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/hypotenuse_approx_refined_unit.sv @@
// approximate hypotenuse unit: length ~= sqrt(x_value^2 + y_value^2)
// input channel in_ch carries a signed pair (x_value, y_value), output channel
// out_ch carries the unsigned 32-bit length; both use valid/ready, a transfer
// happens on a rising edge with valid and ready high
// each pair gives exactly one result, in order; there is no state between pairs
// each pair passes through registers s1..s4, the divider stages and the output
// register s5 before its result is offered on out_ch
// throughput: one pair per cycle unless out_ch stalls; the divider is a pipeline
// of 16 stages resolving 2 quotient bits each; it sets the depth of 21 stages
// every stage has its own valid bit and advances when its successor has room,
// so bubbles are squeezed out and in_ch stays ready while any stage is empty
// when out_ch stalls the result is held in the output register, and up to
// 21 pairs are held in flight before in_ch.ready drops
// reset (arst_n low) empties the pipeline at once; no results come out after it
`default_nettype none
module hypotenuse_approx_refined_unit (
	input wire logic    clk,
	input wire logic    arst_n,
	har_stream_if.sink   in_ch,
	har_stream_if.source out_ch
);
	import har_pkg::*;

	typedef struct packed {
		logic             byp;
		logic [DW-1:0]    byp_val;
		har_tier_t        tier;
		logic [MAG_W-1:0] mn;
		logic [MAG_W-1:0] mx;
	} front_t;

	typedef struct packed {
		logic          byp;
		logic [DW-1:0] byp_val;
		har_tier_t     tier;
		logic [25:0]   pw;
		logic [24:0]   pm;
		logic [31:0]   sqn;
		logic [31:0]   sqx;
	} prod_t;

	function automatic logic [MAG_W-1:0] scale_round(input logic [DW-1:0] v,
			input int unsigned sh);
		logic [DW:0] t;
		t = {1'b0, v} + ((DW+1)'(1) << (sh - 1));
		return MAG_W'(t >> sh);
	endfunction

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic             en1, en2, en3, en4, en5;
	logic [DW-1:0]    ax_s1, ay_s1;
	front_t           f_s2;
	prod_t            p_s3;
	har_div_t         d_s4;
	logic [DW-1:0]    len_s5;

	logic             div_in_ready, div_out_valid;
	har_div_t         div_out;

	front_t           f_nxt;
	logic [DW-1:0]    mn_full, mx_full;
	logic [9:0]       weight;
	logic [26:0]      est_sum;
	logic [EST_W-1:0] est_nxt;
	logic [QW:0]      sum;
	logic [QW+1:0]    sum_rnd;
	logic [DW-1:0]    res;

	// per-stage enables
	assign en5 = !v_s5 || out_ch.ready;
	assign en4 = !v_s4 || div_in_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_ch.ready       = en1;
	assign out_ch.valid      = v_s5;
	assign out_ch.data.length = len_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= div_out_valid;
		end
	end

	// s1: magnitudes, -2^31 maps to 2^31
	always_ff @(posedge clk) begin
		if (en1 && in_ch.valid) begin
			ax_s1 <= in_ch.data.x_value[DW-1] ? DW'(-in_ch.data.x_value) :
				in_ch.data.x_value;
			ay_s1 <= in_ch.data.y_value[DW-1] ? DW'(-in_ch.data.y_value) :
				in_ch.data.y_value;
		end
	end

	// s2: zero legs, ordering, tier and rounding to scale
	always_comb begin
		f_nxt.byp     = (ax_s1 == '0) || (ay_s1 == '0);
		f_nxt.byp_val = (ax_s1 == '0) ? ay_s1 : ax_s1;
		if (ax_s1 < ay_s1) begin
			mn_full = ax_s1;
			mx_full = ay_s1;
		end else begin
			mn_full = ay_s1;
			mx_full = ax_s1;
		end
		if (mx_full < TIER_LIM_0) begin
			f_nxt.tier = TIER_0;
		end else if (mx_full < TIER_LIM_4) begin
			f_nxt.tier = TIER_4;
		end else if (mx_full < TIER_LIM_8) begin
			f_nxt.tier = TIER_8;
		end else if (mx_full < TIER_LIM_12) begin
			f_nxt.tier = TIER_12;
		end else begin
			f_nxt.tier = TIER_16;
		end
		case (f_nxt.tier)
			TIER_0: begin
				f_nxt.mn = mn_full[MAG_W-1:0];
				f_nxt.mx = mx_full[MAG_W-1:0];
			end
			TIER_4: begin
				f_nxt.mn = scale_round(mn_full, 4);
				f_nxt.mx = scale_round(mx_full, 4);
			end
			TIER_8: begin
				f_nxt.mn = scale_round(mn_full, 8);
				f_nxt.mx = scale_round(mx_full, 8);
			end
			TIER_12: begin
				f_nxt.mn = scale_round(mn_full, 12);
				f_nxt.mx = scale_round(mx_full, 12);
			end
			default: begin
				f_nxt.mn = scale_round(mn_full, 16);
				f_nxt.mx = scale_round(mx_full, 16);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			f_s2 <= f_nxt;
		end
	end

	// s3: weights and squares
	assign weight = ({4'b0, f_s2.mx} < {f_s2.mn, 4'b0}) ? W_SMALL : W_LARGE;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			p_s3.byp     <= f_s2.byp;
			p_s3.byp_val <= f_s2.byp_val;
			p_s3.tier    <= f_s2.tier;
			p_s3.pw      <= {10'b0, f_s2.mx} * {16'b0, weight};
			p_s3.pm      <= {9'b0, f_s2.mn} * {16'b0, W_MIN};
			p_s3.sqn     <= {16'b0, f_s2.mn} * {16'b0, f_s2.mn};
			p_s3.sqx     <= {16'b0, f_s2.mx} * {16'b0, f_s2.mx};
		end
	end

	// s4: first estimate and dividend
	assign est_sum = {1'b0, p_s3.pw} + {2'b0, p_s3.pm} + RND_EST;
	assign est_nxt = (est_sum[25:10] == '0) ? EST_W'(1) : est_sum[25:10];

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			d_s4.byp     <= p_s3.byp;
			d_s4.byp_val <= p_s3.byp_val;
			d_s4.tier    <= p_s3.tier;
			d_s4.est     <= est_nxt;
			d_s4.rem     <= '0;
			d_s4.numq    <= p_s3.sqn + p_s3.sqx;
		end
	end

	har_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_data   (d_s4),
		.out_valid (div_out_valid),
		.out_ready (en5),
		.out_data  (div_out)
	);

	// s5: newton sum and scale back
	always_comb begin
		sum     = {1'b0, div_out.numq} + {{(QW+1-EST_W){1'b0}}, div_out.est};
		sum_rnd = {1'b0, sum} + (QW+2)'(1);
		case (div_out.tier)
			TIER_0:  res = sum_rnd[QW:1];
			TIER_4:  res = {sum[28:0], 3'b0};
			TIER_8:  res = {sum[24:0], 7'b0};
			TIER_12: res = {sum[20:0], 11'b0};
			TIER_16: res = {sum[16:0], 15'b0};
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en5 && div_out_valid) begin
			len_s5 <= div_out.byp ? div_out.byp_val : res;
		end
	end

endmodule
`default_nettype wire

@@ sv/har_checker.sv @@
`default_nettype none
module har_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [31:0]   length
);
	import har_pkg::*;

	localparam int unsigned CW = $clog2(HAR_DEPTH + 2);

	logic [CW-1:0] cnt_q;

	// items taken in and not yet handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_valid && in_ready) - CW'(out_valid && out_ready);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without a pending input transfer");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HAR_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_room_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(HAR_DEPTH) |-> in_ready)
		else $error("input stalled while a stage is empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(length))
		else $error("stalled result dropped or changed");

endmodule

bind hypotenuse_approx_refined_unit har_checker u_har_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.length    (out_ch.data.length)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import har_pkg::*;

	localparam int unsigned RANDOM_PAIRS = 1950;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 2 * HAR_DEPTH;

	class hypot_scoreboard;
		logic [DW-1:0] expected_lengths[$];
		int unsigned   mismatches;

		function automatic logic [DW-1:0] predict_length(logic signed [DW-1:0] x,
		                                                 logic signed [DW-1:0] y);
			logic [DW-1:0] ax;
			logic [DW-1:0] ay;
			logic [63:0]   mn;
			logic [63:0]   mx;
			logic [63:0]   weight;
			logic [63:0]   est;
			logic [63:0]   total;
			logic [63:0]   half;
			int unsigned   shift;
			ax = x[DW-1] ? (32'd0 - 32'(x)) : 32'(x);
			ay = y[DW-1] ? (32'd0 - 32'(y)) : 32'(y);
			if (ax == 0)
				return ay;
			if (ay == 0)
				return ax;
			mn = (ax < ay) ? 64'(ax) : 64'(ay);
			mx = (ax < ay) ? 64'(ay) : 64'(ax);
			if (mx < 64'(TIER_LIM_0))
				shift = 0;
			else if (mx < 64'(TIER_LIM_4))
				shift = 4;
			else if (mx < 64'(TIER_LIM_8))
				shift = 8;
			else if (mx < 64'(TIER_LIM_12))
				shift = 12;
			else
				shift = 16;
			if (shift != 0) begin
				half = 64'd1 << (shift - 1);
				mn = (mn + half) >> shift;
				mx = (mx + half) >> shift;
			end
			weight = (mx < (mn << 4)) ? 64'(W_SMALL) : 64'(W_LARGE);
			est = (mx * weight + mn * 64'(W_MIN) + 64'(RND_EST)) >> 10;
			if (est == 0)
				est = 1;
			total = est + (mn * mn + mx * mx) / est;
			if (shift == 0)
				return 32'((total + 1) >> 1);
			return 32'(total << (shift - 1));
		endfunction

		function void note_pair(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
			expected_lengths.push_back(predict_length(x, y));
		endfunction

		function void check_length(logic [DW-1:0] got);
			logic [DW-1:0] want;
			if (expected_lengths.size() == 0) begin
				$display("%0t: unexpected length, expected none, actual %0d", $time, got);
				mismatches++;
				return;
			end
			want = expected_lengths.pop_front();
			if (got !== want) begin
				$display("%0t: length mismatch, expected %0d, actual %0d", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;
	hypot_scoreboard sb = new();

	har_stream_if #(.payload_t(har_in_t))  in_ch ();
	har_stream_if #(.payload_t(har_out_t)) out_ch ();

	hypotenuse_approx_refined_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_pair(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
		int unsigned gap;
		gap = tx_fast ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= '{x_value: x, y_value: y};
		do @(posedge clk); while (!in_ch.ready);
		sb.note_pair(x, y);
		if ($urandom_range(0, 39) == 0)
			tx_fast = !tx_fast;
	endtask

	task automatic receive_lengths();
		int unsigned stall;
		forever begin
			stall = rx_fast ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_length(out_ch.data.length);
			if ($urandom_range(0, 39) == 0)
				rx_fast = !rx_fast;
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.expected_lengths.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] random_leg();
		int unsigned bits;
		logic [DW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = $urandom();
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'hffff_ffff;
					default: v = 32'd1;
				endcase
			end
			default: begin
				bits = $urandom_range(1, 31);
				v = $urandom() & ((32'd1 << bits) - 1);
				if ($urandom_range(0, 1) == 1)
					v = 32'd0 - v;
			end
		endcase
		return v;
	endfunction

	initial begin
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.data   <= '0;
		out_ch.ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_lengths();
		join_none

		// zero legs, most negative legs, tier edges, weight switch, rounded-away small leg
		send_pair(0, 0);
		send_pair(0, 32'sh8000_0000);
		send_pair(32'sh8000_0000, 0);
		send_pair(0, -5);
		send_pair(7, 0);
		send_pair(32'sh8000_0000, 32'sh8000_0000);
		send_pair(32'sh7fff_ffff, 32'sh7fff_ffff);
		send_pair(32'sh8000_0000, 32'sh7fff_ffff);
		send_pair(3, 4);
		send_pair(-3, -4);
		send_pair(1, 1);
		send_pair(-1, -1);
		send_pair(32767, 1);
		send_pair(32768, 1);
		send_pair(-(32'sd1 << 19) + 1, 1000);
		send_pair(32'sd1 << 19, -1000);
		send_pair((32'sd1 << 23) - 1, 12345);
		send_pair(32'sd1 << 23, 12345);
		send_pair((32'sd1 << 27) - 1, 77);
		send_pair(32'sd1 << 27, 77);
		send_pair(32'sd1 << 30, 1);
		send_pair(16, 1);
		send_pair(15, 1);
		send_pair(32'sh7fff_ffff, 1);
		send_pair(1, 32'sh7fff_ffff);
		wait_drained();

		for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
			x = random_leg();
			case ($urandom_range(0, 7))
				0: y = (x >>> 4) + $signed($urandom_range(0, 2)) - 1;
				1: y = -x;
				default: y = random_leg();
			endcase
			if ($urandom_range(0, 1) == 1)
				send_pair(x, y);
			else
				send_pair(y, x);
			if (n == RANDOM_PAIRS / 2)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_lengths.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
